### rtl/core/ckm_pkg.sv
package ckm_pkg;

    // Default depth of the pattern store and the text window.
    localparam int MAX_LEN_DEF = 16;

    // Field widths fixed by the interface.
    localparam int CFG_W  = 5;
    localparam int POS_W  = 4;
    localparam int BYTE_W = 8;
    localparam int OCC_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Item kinds.
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // Register indexes (address bit 2 selects the register).
    localparam logic [0:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [0:0] REG_MAX_MISMATCHES = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } ckm_state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic step;
    } cell_ctl_t;

endpackage

### rtl/core/ckm_cell.sv
module ckm_cell
    import ckm_pkg::*;
#(
    parameter int DW = CFG_W
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [BYTE_W-1:0] pat_init,
    input  logic [BYTE_W-1:0] pat_in,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic [CFG_W-1:0]  max_mm,
    output logic [BYTE_W-1:0] pat_out,
    output logic              hit
);

    localparam int CW = (DW > CFG_W) ? DW : CFG_W;

    logic [BYTE_W-1:0] pat_reg;
    logic [DW-1:0]     diff_reg;

    // On load the cell takes its first pattern byte and clears its count.
    // On each step it counts a mismatch against the broadcast text byte
    // and takes the next pattern byte from its neighbor.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pat_reg  <= pat_init;
            diff_reg <= '0;
        end
        else if (ctl.step)
        begin
            pat_reg <= pat_in;
            if (pat_reg != text_byte)
            begin
                diff_reg <= diff_reg + DW'(1);
            end
        end
    end

    assign pat_out = pat_reg;

    // The rotation held by this cell matches when its count stays in the limit.
    assign hit = (CW'(diff_reg) <= CW'(max_mm));

endmodule

### rtl/core/circular_k_mismatch_matcher_core.sv
// Circular k-mismatch matcher. Pattern bytes are loaded with kind 0. A text
// byte (kind 1) goes to the finish step while the window is not yet full, and
// once it is, first through a compare phase over the effective length, where
// the effective length is pattern_length taken as 1 when zero and as MAX_LEN
// when above it: a chain of MAX_LEN cells, one per pattern rotation, compares
// the window against all rotations at once, one window byte per cycle, while
// the pattern bytes circulate from cell to cell. The result sits in an output
// register, so the next item is taken while a finished result still waits for
// its transfer; a result only holds up the block when the one before it is
// still waiting. Configuration is to be written through the APB-style port
// while the block is idle; the block itself does not enforce this.
module circular_k_mismatch_matcher_core
    import ckm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Input channel.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              starts_text,
    // Output channel.
    output logic              out_valid,
    input  logic              out_ready,
    output logic              window_full,
    output logic              match,
    output logic [OCC_W-1:0]  occurrences
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = $clog2(MAX_LEN);

    // Configuration registers.
    logic [CFG_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] max_mismatches_reg;
    logic [0:0]       cfg_idx;
    logic             cfg_write;

    // Storage and working state.
    logic [BYTE_W-1:0] pattern_reg [MAX_LEN];
    logic [BYTE_W-1:0] window_reg  [MAX_LEN];
    logic [BYTE_W-1:0] snap_reg    [MAX_LEN];
    logic [LW-1:0]     fill_reg;
    logic [LW-1:0]     fill_next;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_eff;
    logic [LW-1:0]     step_cnt_reg;
    logic              full_reg;
    logic              full_next;
    logic [OCC_W-1:0]  count_reg;
    logic [OCC_W-1:0]  count_next;
    ckm_state_t        state_reg;
    ckm_state_t        state_next;

    // Output register.
    logic              out_valid_reg;
    logic              window_full_reg;
    logic              match_reg;
    logic [OCC_W-1:0]  occ_reg;

    // Handshake and sequencer controls.
    logic              in_xfer;
    logic              text_xfer;
    logic              pat_xfer;
    logic              slot_free;
    logic              finish_fire;
    cell_ctl_t         cell_ctl;

    // Cell chain signals.
    logic [BYTE_W-1:0] cell_pat [MAX_LEN];
    logic [BYTE_W-1:0] cell_init [MAX_LEN];
    logic [BYTE_W-1:0] cell_in [MAX_LEN];
    logic [MAX_LEN-1:0] cell_hit;
    logic [MAX_LEN-1:0] hit_vec;
    logic              hit_any;

    // Register access: bit 2 of the address picks the register.
    assign cfg_idx   = paddr[2:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= CFG_W'(1);
            max_mismatches_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[CFG_W-1:0];
                REG_MAX_MISMATCHES: max_mismatches_reg <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_reg);
            REG_MAX_MISMATCHES: prdata = DATA_W'(max_mismatches_reg);
            default:            prdata = '0;
        endcase
    end

    // Effective length: zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (32'(pattern_length_reg) > 32'(MAX_LEN))
        begin
            len_eff = LW'(MAX_LEN);
        end
        else
        begin
            len_eff = LW'(pattern_length_reg);
        end
    end

    // Input transfers.
    assign in_xfer   = in_valid && in_ready;
    assign text_xfer = in_xfer && (kind == KIND_TEXT);
    assign pat_xfer  = in_xfer && (kind == KIND_PATTERN);
    assign slot_free = !out_valid_reg || out_ready;

    // Fill count after this text byte, saturating at the depth.
    always_comb
    begin
        fill_next = starts_text ? '0 : fill_reg;
        if (32'(fill_next) < 32'(MAX_LEN))
        begin
            fill_next = fill_next + LW'(1);
        end
        full_next = (fill_next >= len_eff);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_xfer)
                begin
                    state_next = full_next ? ST_CALC : ST_FINISH;
                end
            end
            ST_CALC:
            begin
                if (step_cnt_reg == LW'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready      = 1'b0;
        cell_ctl.step = 1'b0;
        finish_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready      = 1'b1;
            ST_CALC:   cell_ctl.step = 1'b1;
            ST_FINISH: finish_fire   = slot_free;
            default:   ;
        endcase
        cell_ctl.load = text_xfer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pattern store: loads beyond the depth are dropped.
    always_ff @(posedge clk)
    begin
        if (pat_xfer && (32'(position) < 32'(MAX_LEN)))
        begin
            pattern_reg[IW'(position)] <= byte_value;
        end
    end

    // Text window shifts in each text byte; the snapshot copy does the same
    // on a text transfer and then shifts toward its tap once per step,
    // presenting the window newest byte first.
    always_ff @(posedge clk)
    begin
        if (text_xfer)
        begin
            for (int i = 0; i < MAX_LEN - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
                snap_reg[i]   <= window_reg[i + 1];
            end
            window_reg[MAX_LEN - 1] <= byte_value;
            snap_reg[MAX_LEN - 1]   <= byte_value;
        end
        else if (cell_ctl.step)
        begin
            for (int i = MAX_LEN - 1; i > 0; i--)
            begin
                snap_reg[i] <= snap_reg[i - 1];
            end
        end
    end

    // Per-text working state: length, step count and fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            len_reg      <= LW'(1);
            step_cnt_reg <= '0;
            full_reg     <= 1'b0;
        end
        else if (text_xfer)
        begin
            fill_reg     <= fill_next;
            len_reg      <= len_eff;
            step_cnt_reg <= len_eff;
            full_reg     <= full_next;
        end
        else if (cell_ctl.step)
        begin
            step_cnt_reg <= step_cnt_reg - LW'(1);
        end
    end

    // Cell chain. Cell r compares rotation r; it starts on the pattern byte
    // that lines up with the newest window byte and takes its next byte from
    // the cell before it, with cell zero closing the ring at the length.
    generate
        for (genvar r = 0; r < MAX_LEN; r++)
        begin : g_cell
            if (r == 0)
            begin : g_head
                assign cell_init[r] = pattern_reg[IW'(len_eff - LW'(1))];
                assign cell_in[r]   = cell_pat[IW'(len_reg - LW'(1))];
            end
            else
            begin : g_body
                assign cell_init[r] = pattern_reg[r - 1];
                assign cell_in[r]   = cell_pat[r - 1];
            end

            ckm_cell #(
                .DW (LW)
            ) u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .pat_init  (cell_init[r]),
                .pat_in    (cell_in[r]),
                .text_byte (snap_reg[MAX_LEN - 1]),
                .max_mm    (max_mismatches_reg),
                .pat_out   (cell_pat[r]),
                .hit       (cell_hit[r])
            );

            assign hit_vec[r] = cell_hit[r] && (len_reg > LW'(r));
        end
    endgenerate

    assign hit_any = full_reg && (|hit_vec);

    // Running count of matching windows, saturating at all ones.
    always_comb
    begin
        count_next = count_reg;
        if (text_xfer && starts_text)
        begin
            count_next = '0;
        end
        else if (finish_fire && hit_any && (count_reg != '1))
        begin
            count_next = count_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            window_full_reg <= full_reg;
            match_reg       <= hit_any;
            occ_reg         <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign window_full = window_full_reg;
    assign match       = match_reg;
    assign occurrences = occ_reg;

endmodule

### rtl/core/ckm_checker.sv
module ckm_checker
    import ckm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             kind,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             window_full,
    input  logic             match,
    input  logic [OCC_W-1:0] occurrences
);

    // A waiting result holds its payload until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(occurrences)
            && $stable(match) && $stable(window_full))
        else $error("result changed while waiting for transfer");

    // A window that is not yet full never matches.
    a_no_early_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> !match)
        else $error("match reported on a window that is not full");

    // A matching window is always counted.
    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match |-> occurrences != '0)
        else $error("match reported with a zero count");

    // After a text transfer the block is busy judging it.
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_TEXT) |=> !in_ready)
        else $error("input taken while a text byte is still in progress");

endmodule

bind circular_k_mismatch_matcher_core ckm_checker u_ckm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_full (window_full),
    .match       (match),
    .occurrences (occurrences)
);

### dv/tb_top.sv
module tb_top
    import ckm_pkg::*;
();

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 34;

    // One text byte verdict as the block reports it.
    typedef struct packed {
        logic             full;
        logic             hit;
        logic [OCC_W-1:0] occ;
    } verdict_t;

    // One directed stimulus row; a typed verdict is used where chk is set.
    typedef struct packed {
        logic              k;
        logic [POS_W-1:0]  p;
        logic [BYTE_W-1:0] b;
        logic              s;
        logic              chk;
        verdict_t          v;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_PATTERN;
    logic [POS_W-1:0]  position = '0;
    logic [BYTE_W-1:0] byte_value = '0;
    logic              starts_text = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              window_full;
    logic              match;
    logic [OCC_W-1:0]  occurrences;

    // Predictor state: its own copy of the stores and the registers.
    logic [BYTE_W-1:0] pat_mem [MAX_LEN];
    logic [BYTE_W-1:0] win_mem [MAX_LEN];
    int unsigned       fill_cnt = 0;
    logic [OCC_W-1:0]  hit_cnt = '0;
    logic [CFG_W-1:0]  cfg_len = 5'd1;
    logic [CFG_W-1:0]  cfg_kmax = 5'd0;

    verdict_t    verdict_q [$];
    int unsigned fail_cnt = 0;
    int unsigned cyc_cnt = 0;
    int unsigned burst_left = 0;
    bit          quiet = 1'b0;
    int unsigned sink_mode = 0;
    int unsigned sink_left = 0;
    verdict_t    got_v;
    verdict_t    want_v;

    circular_k_mismatch_matcher_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .position    (position),
        .byte_value  (byte_value),
        .starts_text (starts_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_full (window_full),
        .match       (match),
        .occurrences (occurrences)
    );

    always #5 clk = ~clk;

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s", msg);
    endfunction

    // Window length in use: zero acts as one, anything above the depth as the depth.
    function automatic int unsigned used_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > MAX_LEN)
            return MAX_LEN;
        return 32'(cfg_len);
    endfunction

    // True when the newest n window bytes are within the limit of some rotation.
    function automatic logic any_rotation_fits(input int unsigned n);
        int unsigned base;
        int unsigned idx;
        int unsigned diff;
        base = MAX_LEN - n;
        for (int unsigned rot = 0; rot < n; rot++)
        begin
            diff = 0;
            idx = rot;
            for (int unsigned j = 0; j < n; j++)
            begin
                if (win_mem[base + j] != pat_mem[idx])
                    diff++;
                idx++;
                if (idx == n)
                    idx = 0;
            end
            if (diff <= cfg_kmax)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Shifts one text byte into the window and judges the window.
    function automatic verdict_t judge_text_byte(input logic [BYTE_W-1:0] b, input logic s);
        verdict_t    v;
        int unsigned n;
        if (s)
        begin
            for (int i = 0; i < MAX_LEN; i++)
                win_mem[i] = '0;
            fill_cnt = 0;
            hit_cnt = '0;
        end
        for (int i = 0; i < MAX_LEN - 1; i++)
            win_mem[i] = win_mem[i + 1];
        win_mem[MAX_LEN - 1] = b;
        if (fill_cnt < MAX_LEN)
            fill_cnt++;
        n = used_len();
        v.full = (fill_cnt >= n);
        v.hit = 1'b0;
        if (v.full)
        begin
            v.hit = any_rotation_fits(n);
            if (v.hit && hit_cnt != '1)
                hit_cnt++;
        end
        v.occ = hit_cnt;
        return v;
    endfunction

    // Offers one item in bursts with random gaps, then records the pattern byte or the expected verdict.
    task automatic send_item(input logic k, input logic [POS_W-1:0] p,
                             input logic [BYTE_W-1:0] b, input logic s,
                             input logic chk, input verdict_t typed_v);
        int unsigned gap;
        verdict_t    v;
        if (burst_left == 0)
        begin
            gap = quiet ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        position <= p;
        byte_value <= b;
        starts_text <= s;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (k == KIND_PATTERN)
            pat_mem[p] = b;
        else
        begin
            v = judge_text_byte(b, s);
            verdict_q.push_back(chk ? typed_v : v);
        end
    endtask

    // Setup and access cycle of one register write; psel is left high.
    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(DATA_W - CFG_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_PATTERN_LENGTH)
            cfg_len = val;
        else
            cfg_kmax = val;
    endtask

    // Drains the block: all verdicts back, then enough cycles for a pattern load.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (MAX_LEN + 4) @(posedge clk);
    endtask

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_v = '{window_full, match, occurrences};
            if (verdict_q.size() == 0)
                note_fail($sformatf("unexpected result: full %0b match %0b occ %0d",
                                    window_full, match, occurrences));
            else
            begin
                want_v = verdict_q.pop_front();
                if (got_v.full !== want_v.full || got_v.hit !== want_v.hit
                    || got_v.occ !== want_v.occ)
                    note_fail($sformatf({"mismatch: full exp %0b got %0b, ",
                                         "match exp %0b got %0b, occ exp %0d got %0d"},
                                        want_v.full, got_v.full, want_v.hit, got_v.hit,
                                        want_v.occ, got_v.occ));
            end
        end
    end

    // Cycle limit and the receiver's stall pattern.
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        if (sink_left == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(50, 300);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= cyc_cnt[0];
            2: out_ready <= ($urandom_range(0, 2) != 0);
            default: out_ready <= (cyc_cnt[3:0] < 4'd3);
        endcase
    end

    initial
    begin
        // Pattern is filled first so that no window is judged against an unwritten entry.
        static stim_row_t dir_rows [21] = '{
            '{KIND_PATTERN, 4'd0,  8'hA5, 1'b1, 1'b0, '0},
            '{KIND_PATTERN, 4'd1,  8'h00, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd2,  8'h41, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd3,  8'h42, 1'b1, 1'b0, '0},
            '{KIND_PATTERN, 4'd4,  8'h41, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd5,  8'h43, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd6,  8'h42, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd7,  8'h40, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd8,  8'h41, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd9,  8'h42, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd10, 8'h43, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd11, 8'h40, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd12, 8'h5A, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd13, 8'h41, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd14, 8'h42, 1'b0, 1'b0, '0},
            '{KIND_PATTERN, 4'd15, 8'hFF, 1'b0, 1'b0, '0},
            // Length one, no mismatch allowed: the window is the newest byte.
            '{KIND_TEXT, 4'd0,  8'hA5, 1'b1, 1'b1, '{1'b1, 1'b1, 32'd1}},
            '{KIND_TEXT, 4'd15, 8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 32'd1}},
            '{KIND_TEXT, 4'd7,  8'hA5, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd2}},
            '{KIND_TEXT, 4'd0,  8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 32'd0}},
            '{KIND_TEXT, 4'd15, 8'hA5, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd1}}
        };
        // Register settings per phase, extremes and out-of-range lengths among them.
        static int unsigned ph_len [NUM_PHASES] = '{16, 4, 0, 16, 3, 31, 8, 2, 6, 17, 5, 1};
        static int unsigned ph_kmax [NUM_PHASES] = '{0, 1, 0, 16, 0, 2, 31, 1, 2, 3, 0, 0};
        int unsigned       rot_pos;
        int unsigned       r;
        logic              k;
        logic [POS_W-1:0]  p;
        logic [BYTE_W-1:0] b;
        logic              s;

        for (int i = 0; i < MAX_LEN; i++)
        begin
            pat_mem[i] = '0;
            win_mem[i] = '0;
        end
        rot_pos = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings.
        foreach (dir_rows[i])
            send_item(dir_rows[i].k, dir_rows[i].p, dir_rows[i].b, dir_rows[i].s,
                      dir_rows[i].chk, dir_rows[i].v);

        // Random part: mostly pattern rotations with some corruption, plus noise.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            write_reg(REG_PATTERN_LENGTH, ph_len[ph][CFG_W-1:0]);
            write_reg(REG_MAX_MISMATCHES, ph_kmax[ph][CFG_W-1:0]);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            quiet = (ph % 3 == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    k = KIND_PATTERN;
                    p = POS_W'($urandom);
                    b = $urandom_range(0, 1) ? 8'h40 + BYTE_W'($urandom_range(0, 3))
                                             : BYTE_W'($urandom);
                    s = 1'($urandom);
                end
                else
                begin
                    k = KIND_TEXT;
                    p = POS_W'($urandom);
                    s = (r < 10) || (n == 0 && ph % 2 == 0);
                    if (s)
                        rot_pos = $urandom_range(0, MAX_LEN - 1);
                    rot_pos = rot_pos % used_len();
                    if ($urandom_range(0, 9) < 7)
                    begin
                        b = pat_mem[rot_pos];
                        if ($urandom_range(0, 9) == 0)
                            b = BYTE_W'($urandom);
                    end
                    else
                        b = $urandom_range(0, 1) ? 8'h40 + BYTE_W'($urandom_range(0, 3))
                                                 : BYTE_W'($urandom);
                    rot_pos = (rot_pos + 1) % used_len();
                end
                send_item(k, p, b, s, 1'b0, '0);
            end
        end

        // Wait for the last verdicts, then a little longer for stray transfers.
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_LEN + 8) @(posedge clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
